>>> src/z80s_pkg.sv
// package for the z80 subset step core: command codes, opcodes, flag bits, widths
// no dependencies
package z80s_pkg;

    localparam int MemAddrBits = 16;

    localparam logic [1:0] CMD_WRITE = 2'd0;
    localparam logic [1:0] CMD_READ  = 2'd1;
    localparam logic [1:0] CMD_STEP  = 2'd2;

    localparam logic [7:0] OP_NOP     = 8'h00;
    localparam logic [7:0] OP_LD_BC   = 8'h01;
    localparam logic [7:0] OP_ST_BC   = 8'h02;
    localparam logic [7:0] OP_INC_BC  = 8'h03;
    localparam logic [7:0] OP_INC_B   = 8'h04;
    localparam logic [7:0] OP_DEC_B   = 8'h05;
    localparam logic [7:0] OP_LD_B    = 8'h06;
    localparam logic [7:0] OP_RLCA    = 8'h07;
    localparam logic [7:0] OP_EX_AF   = 8'h08;
    localparam logic [7:0] OP_ADD_BC  = 8'h09;
    localparam logic [7:0] OP_LDA_BC  = 8'h0A;
    localparam logic [7:0] OP_DEC_BC  = 8'h0B;
    localparam logic [7:0] OP_INC_C   = 8'h0C;
    localparam logic [7:0] OP_DEC_C   = 8'h0D;
    localparam logic [7:0] OP_LD_C    = 8'h0E;
    localparam logic [7:0] OP_RRCA    = 8'h0F;
    localparam logic [7:0] OP_DJNZ    = 8'h10;
    localparam logic [7:0] OP_LD_DE   = 8'h11;
    localparam logic [7:0] OP_ST_DE   = 8'h12;
    localparam logic [7:0] OP_INC_DE  = 8'h13;
    localparam logic [7:0] OP_INC_D   = 8'h14;
    localparam logic [7:0] OP_DEC_D   = 8'h15;
    localparam logic [7:0] OP_LD_D    = 8'h16;
    localparam logic [7:0] OP_RLA     = 8'h17;
    localparam logic [7:0] OP_JR      = 8'h18;
    localparam logic [7:0] OP_ADD_DE  = 8'h19;
    localparam logic [7:0] OP_HALT    = 8'h76;

    localparam logic [7:0] F_SZPV = 8'hC4;
    localparam logic [7:0] F_YX   = 8'h28;
    localparam logic [7:0] F_SYX  = 8'hA8;

    // command as passed from the front end to the executor
    typedef struct packed {
        logic [1:0]  cmd;
        logic [15:0] addr;
        logic [7:0]  wdata;
    } t_cmd;

    // number of operand bytes after the opcode
    function automatic logic [1:0] operand_count(input logic [7:0] op);
        logic [1:0] n;
        begin
            n = 2'd0;
            if (op == OP_LD_BC || op == OP_LD_DE) n = 2'd2;
            else if (op == OP_LD_B || op == OP_LD_C || op == OP_LD_D
                     || op == OP_DJNZ || op == OP_JR) n = 2'd1;
            return n;
        end
    endfunction

endpackage

>>> src/z80_subset_instruction_step_core.sv
// top level of the z80 subset step core: command queue, sequencer and memory
// uses z80s_pkg, z80s_front, z80s_exec
//
// channel | dir | tdata fields (lsb first)
// s_axis  | in  | command[1:0], address[17:2], write_data[25:18]
// m_axis  | out | read_data, program_counter, accumulator, flags, pair_bc,
//         |     | pair_de, pair_hl, halted, unsupported
//
// write, unknown and halted-step commands go straight to the result state; a read or step
// takes one state per memory access (opcode, operands, data byte) on the single ram port plus a
// result state; nop, 16-bit add and load a,(bc) also pass through the S_MEM state.
// a two-word queue takes new commands while the sequencer is busy.
// reset clears registers and control; memory holds garbage until written.
// a stalled result holds in the output register; the sequencer waits for it to drain.
module z80_subset_instruction_step_core #(
    parameter int MemAddrBits = z80s_pkg::MemAddrBits
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [31:0]  s_axis_tdata,  // command, address, write_data
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [95:0]  m_axis_tdata   // read_data, program_counter, accumulator, flags,
                                        // pair_bc, pair_de, pair_hl, halted, unsupported
);
    z80s_pkg::t_cmd in_cmd, q_cmd;
    logic q_valid, q_pop;

    assign in_cmd.cmd   = s_axis_tdata[1:0];
    assign in_cmd.addr  = s_axis_tdata[17:2];
    assign in_cmd.wdata = s_axis_tdata[25:18];

    z80s_front #(.Depth(2)) u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(s_axis_tvalid), .o_ready(s_axis_tready), .i_cmd(in_cmd),
        .o_valid(q_valid), .i_pop(q_pop), .o_cmd(q_cmd)
    );

    z80s_exec #(.MemAddrBits(MemAddrBits)) u_exec (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(q_valid), .o_pop(q_pop), .i_cmd(q_cmd),
        .o_valid(m_axis_tvalid), .i_ready(m_axis_tready), .o_data(m_axis_tdata)
    );
endmodule

>>> src/z80s_ram.sv
// generic single-port ram with registered read
// no dependencies
module z80s_ram #(
    parameter int Width = 8,
    parameter int Depth = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(Depth)-1:0] i_addr,
    input  logic [Width-1:0]         i_wdata,
    output logic [Width-1:0]         o_rdata
);
    logic [Width-1:0] r_mem [Depth];
    logic [Width-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;
endmodule

>>> src/z80s_front.sv
// front end: accepts command words into a short queue
// uses z80s_pkg
module z80s_front #(
    parameter int Depth = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  z80s_pkg::t_cmd   i_cmd,
    output logic             o_valid,
    input  logic             i_pop,
    output z80s_pkg::t_cmd   o_cmd
);
    localparam int PtrBits = (Depth > 1) ? $clog2(Depth) : 1;

    z80s_pkg::t_cmd r_q [Depth];
    logic [PtrBits-1:0] r_wp, r_rp;
    logic [PtrBits:0]   r_cnt;
    logic push, pop;

    assign o_ready = (r_cnt != (PtrBits+1)'(Depth));
    assign o_valid = (r_cnt != '0);
    assign push = i_valid && o_ready;
    assign pop  = i_pop && o_valid;
    assign o_cmd = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0;
            r_rp <= '0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_q[r_wp] <= i_cmd;
                r_wp <= (r_wp == PtrBits'(Depth-1)) ? '0 : r_wp + 1'b1;
            end
            if (pop) begin
                r_rp <= (r_rp == PtrBits'(Depth-1)) ? '0 : r_rp + 1'b1;
            end
            r_cnt <= r_cnt + (PtrBits+1)'(push) - (PtrBits+1)'(pop);
        end
    end
endmodule

>>> src/z80s_exec.sv
// back end: sequencer that carries out one command at a time over the single ram port
// uses z80s_pkg, z80s_ram
module z80s_exec #(
    parameter int MemAddrBits = z80s_pkg::MemAddrBits
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_pop,
    input  z80s_pkg::t_cmd i_cmd,
    output logic           o_valid,
    input  logic           i_ready,
    output logic [95:0]    o_data
);
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_OP   = 3'd1;
    localparam logic [2:0] S_B1   = 3'd2;
    localparam logic [2:0] S_B2   = 3'd3;
    localparam logic [2:0] S_MEM  = 3'd4;
    localparam logic [2:0] S_RD   = 3'd5;
    localparam logic [2:0] S_DONE = 3'd6;

    logic [2:0]  r_st, n_st;
    logic [15:0] r_pc, n_pc, r_bc, n_bc, r_de, n_de, r_hl, n_hl, r_alt, n_alt;
    logic [7:0]  r_a, n_a, r_f, n_f, r_op, n_op, r_b1, n_b1, r_rd, n_rd;
    logic        r_halt, n_halt, r_uns, n_uns;
    logic        r_ov, n_ov;
    logic [95:0] r_out, n_out;

    logic [MemAddrBits-1:0] mem_addr;
    logic        mem_we;
    logic [7:0]  mem_wd, mem_rd;

    z80s_ram #(.Width(8), .Depth(2 ** MemAddrBits)) u_ram (
        .i_clk(i_clk), .i_we(mem_we), .i_addr(mem_addr),
        .i_wdata(mem_wd), .o_rdata(mem_rd)
    );

    logic can_issue;
    assign can_issue = !r_ov || i_ready;
    assign o_valid = r_ov;
    assign o_data  = r_out;

    function automatic logic [15:0] inc8(input logic [7:0] v, input logic [7:0] f);
        logic [7:0] r, nf;
        begin
            r = v + 8'd1;
            nf = (f & 8'h01) | (r & z80s_pkg::F_SYX) | ((r == 8'd0) ? 8'h40 : 8'h00)
               | ((v[3:0] == 4'hF) ? 8'h10 : 8'h00) | ((v == 8'h7F) ? 8'h04 : 8'h00);
            return {r, nf};
        end
    endfunction

    function automatic logic [15:0] dec8(input logic [7:0] v, input logic [7:0] f);
        logic [7:0] r, nf;
        begin
            r = v - 8'd1;
            nf = (f & 8'h01) | (r & z80s_pkg::F_SYX) | ((r == 8'd0) ? 8'h40 : 8'h00)
               | ((v[3:0] == 4'h0) ? 8'h10 : 8'h00) | ((v == 8'h80) ? 8'h04 : 8'h00)
               | 8'h02;
            return {r, nf};
        end
    endfunction

    logic [16:0] sum;
    logic [12:0] hsum;
    logic [15:0] addv, t16;
    logic [7:0]  rot;

    always_comb begin
        n_st = r_st; n_pc = r_pc; n_bc = r_bc; n_de = r_de; n_hl = r_hl;
        n_alt = r_alt; n_a = r_a; n_f = r_f; n_op = r_op; n_b1 = r_b1;
        n_rd = r_rd; n_halt = r_halt; n_uns = r_uns;
        n_ov = r_ov && !i_ready; n_out = r_out;
        o_pop = 1'b0;
        mem_we = 1'b0;
        mem_addr = i_cmd.addr[MemAddrBits-1:0];
        mem_wd = i_cmd.wdata;
        addv = (r_op == z80s_pkg::OP_ADD_BC) ? r_bc : r_de;
        sum = {1'b0, r_hl} + {1'b0, addv};
        hsum = {1'b0, r_hl[11:0]} + {1'b0, addv[11:0]};
        t16 = '0; rot = '0;
        unique case (r_st)
            S_IDLE: begin
                if (i_valid && can_issue) begin
                    n_uns = 1'b0;
                    n_rd = 8'd0;
                    unique case (i_cmd.cmd)
                        z80s_pkg::CMD_WRITE: begin
                            mem_we = 1'b1;
                            o_pop = 1'b1;
                            n_st = S_DONE;
                        end
                        z80s_pkg::CMD_READ: begin
                            o_pop = 1'b1;
                            n_st = S_RD;
                        end
                        z80s_pkg::CMD_STEP: begin
                            o_pop = 1'b1;
                            if (r_halt) begin
                                n_st = S_DONE;
                            end else begin
                                mem_addr = r_pc[MemAddrBits-1:0];
                                n_pc = r_pc + 16'd1;
                                n_st = S_OP;
                            end
                        end
                        default: begin
                            o_pop = 1'b1;
                            n_st = S_DONE;
                        end
                    endcase
                end
            end
            S_RD: begin
                n_rd = mem_rd;
                n_st = S_DONE;
            end
            S_OP: begin
                n_op = mem_rd;
                if (z80s_pkg::operand_count(mem_rd) != 2'd0) begin
                    mem_addr = r_pc[MemAddrBits-1:0];
                    n_pc = r_pc + 16'd1;
                    n_st = S_B1;
                end else begin
                    n_st = S_DONE;
                    mem_addr = r_bc[MemAddrBits-1:0];
                    unique case (mem_rd)
                        z80s_pkg::OP_NOP, z80s_pkg::OP_ADD_BC, z80s_pkg::OP_ADD_DE: begin
                            n_st = S_MEM;
                        end
                        z80s_pkg::OP_ST_BC: begin
                            mem_we = 1'b1; mem_wd = r_a;
                        end
                        z80s_pkg::OP_ST_DE: begin
                            mem_we = 1'b1; mem_wd = r_a;
                            mem_addr = r_de[MemAddrBits-1:0];
                        end
                        z80s_pkg::OP_INC_BC: n_bc = r_bc + 16'd1;
                        z80s_pkg::OP_DEC_BC: n_bc = r_bc - 16'd1;
                        z80s_pkg::OP_INC_DE: n_de = r_de + 16'd1;
                        z80s_pkg::OP_INC_B: begin
                            t16 = inc8(r_bc[15:8], r_f); n_bc[15:8] = t16[15:8]; n_f = t16[7:0];
                        end
                        z80s_pkg::OP_DEC_B: begin
                            t16 = dec8(r_bc[15:8], r_f); n_bc[15:8] = t16[15:8]; n_f = t16[7:0];
                        end
                        z80s_pkg::OP_INC_C: begin
                            t16 = inc8(r_bc[7:0], r_f); n_bc[7:0] = t16[15:8]; n_f = t16[7:0];
                        end
                        z80s_pkg::OP_DEC_C: begin
                            t16 = dec8(r_bc[7:0], r_f); n_bc[7:0] = t16[15:8]; n_f = t16[7:0];
                        end
                        z80s_pkg::OP_INC_D: begin
                            t16 = inc8(r_de[15:8], r_f); n_de[15:8] = t16[15:8]; n_f = t16[7:0];
                        end
                        z80s_pkg::OP_DEC_D: begin
                            t16 = dec8(r_de[15:8], r_f); n_de[15:8] = t16[15:8]; n_f = t16[7:0];
                        end
                        z80s_pkg::OP_RLCA: begin
                            rot = {r_a[6:0], r_a[7]}; n_a = rot;
                            n_f = (r_f & z80s_pkg::F_SZPV) | (rot & z80s_pkg::F_YX) | {7'd0, r_a[7]};
                        end
                        z80s_pkg::OP_RRCA: begin
                            rot = {r_a[0], r_a[7:1]}; n_a = rot;
                            n_f = (r_f & z80s_pkg::F_SZPV) | (rot & z80s_pkg::F_YX) | {7'd0, r_a[0]};
                        end
                        z80s_pkg::OP_RLA: begin
                            rot = {r_a[6:0], r_f[0]}; n_a = rot;
                            n_f = (r_f & z80s_pkg::F_SZPV) | (rot & z80s_pkg::F_YX) | {7'd0, r_a[7]};
                        end
                        z80s_pkg::OP_EX_AF: begin
                            n_alt = {r_a, r_f}; n_a = r_alt[15:8]; n_f = r_alt[7:0];
                        end
                        z80s_pkg::OP_LDA_BC: n_st = S_MEM;
                        z80s_pkg::OP_HALT: n_halt = 1'b1;
                        default: n_uns = 1'b1;
                    endcase
                end
            end
            S_MEM: begin
                // second half of load a,(bc), nop and 16-bit add
                n_st = S_DONE;
                if (r_op == z80s_pkg::OP_LDA_BC) begin
                    n_a = mem_rd;
                end else if (r_op != z80s_pkg::OP_NOP) begin
                    n_hl = sum[15:0];
                    n_f = (r_f & z80s_pkg::F_SZPV) | (sum[15:8] & z80s_pkg::F_YX)
                        | {3'd0, hsum[12], 3'd0, sum[16]};
                end
            end
            S_B1: begin
                n_b1 = mem_rd;
                n_st = S_DONE;
                unique case (r_op)
                    z80s_pkg::OP_LD_BC, z80s_pkg::OP_LD_DE: begin
                        mem_addr = r_pc[MemAddrBits-1:0];
                        n_pc = r_pc + 16'd1;
                        n_st = S_B2;
                    end
                    z80s_pkg::OP_LD_B: n_bc[15:8] = mem_rd;
                    z80s_pkg::OP_LD_C: n_bc[7:0] = mem_rd;
                    z80s_pkg::OP_LD_D: n_de[15:8] = mem_rd;
                    z80s_pkg::OP_DJNZ: begin
                        n_bc[15:8] = r_bc[15:8] - 8'd1;
                        if (r_bc[15:8] != 8'd1) begin
                            n_pc = r_pc + {{8{mem_rd[7]}}, mem_rd};
                        end
                    end
                    default: n_pc = r_pc + {{8{mem_rd[7]}}, mem_rd};
                endcase
            end
            S_B2: begin
                n_st = S_DONE;
                if (r_op == z80s_pkg::OP_LD_BC) n_bc = {mem_rd, r_b1};
                else n_de = {mem_rd, r_b1};
            end
            S_DONE: begin
                n_st = S_IDLE;
                n_ov = 1'b1;
                n_out = {6'd0, r_uns, r_halt, r_hl, r_de, r_bc, r_f, r_a, r_pc, r_rd};
            end
            default: n_st = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_IDLE; r_pc <= '0; r_a <= '0; r_f <= '0; r_bc <= '0;
            r_de <= '0; r_hl <= '0; r_alt <= '0; r_halt <= 1'b0; r_ov <= 1'b0;
            r_uns <= 1'b0; r_rd <= '0;
        end else begin
            r_st <= n_st; r_pc <= n_pc; r_a <= n_a; r_f <= n_f; r_bc <= n_bc;
            r_de <= n_de; r_hl <= n_hl; r_alt <= n_alt; r_halt <= n_halt;
            r_ov <= n_ov; r_uns <= n_uns; r_rd <= n_rd;
        end
        r_op <= n_op; r_b1 <= n_b1; r_out <= n_out;
    end
endmodule

>>> src/z80s_checker.sv
// port-level checks for the z80 subset step core
// bound to z80_subset_instruction_step_core
module z80s_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [95:0] m_axis_tdata
);
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result word dropped while stalled");
    a_halt_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tready && m_axis_tdata[88] |=>
        !m_axis_tvalid || m_axis_tdata[88])
        else $error("halted cleared without reset");
    a_halt_uns: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !(m_axis_tdata[89] && m_axis_tdata[88]))
        else $error("unsupported reported with halted set");
    a_rst: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid right after reset");
    // queue is empty right after reset
    a_rst_ready: assert property (@(posedge i_clk)
        !i_rst_n |=> s_axis_tready)
        else $error("input not ready right after reset");
endmodule

bind z80_subset_instruction_step_core z80s_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n),
    .s_axis_tready(s_axis_tready),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
);

>>> verif/tb.sv
// testbench for z80_subset_instruction_step_core: directed and random command streams
// checked against an in-bench cpu model; depends on z80s_pkg and the core rtl
`timescale 1ns / 1ps

module tb;

    localparam logic [1:0] CMD_NONE = 2'd3;
    localparam logic [7:0] FLG_C  = 8'h01;
    localparam logic [7:0] FLG_N  = 8'h02;
    localparam logic [7:0] FLG_PV = 8'h04;
    localparam logic [7:0] FLG_H  = 8'h10;
    localparam logic [7:0] FLG_Z  = 8'h40;
    localparam int IDLE_LIMIT = 5000;

    typedef struct packed {
        logic [7:0]  rdata;
        logic [15:0] pc;
        logic [7:0]  acc;
        logic [7:0]  flags;
        logic [15:0] bc;
        logic [15:0] de;
        logic [15:0] hl;
        logic        halted;
        logic        unsup;
    } t_cpu_view;

    logic         i_clk;
    logic         i_rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [31:0]  s_axis_tdata;   // command, address, write_data
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [95:0]  m_axis_tdata;   // read_data, program_counter, accumulator, flags,
                                  // pair_bc, pair_de, pair_hl, halted, unsupported

    z80_subset_instruction_step_core u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata)
    );

    // cpu model state
    logic [15:0] cpu_pc, cpu_bc, cpu_de, cpu_hl, cpu_af_alt;
    logic [7:0]  cpu_a, cpu_f;
    logic        cpu_halt;
    logic [7:0]  cpu_mem [0:65535];
    bit          mem_valid [0:65535];

    t_cpu_view expected_q[$];
    int        mismatches = 0;
    int        idle_pct;
    int        stall_pct;
    int        idle_cycles = 0;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic logic [7:0] fetch_byte();
        logic [7:0] b;
        b = cpu_mem[cpu_pc];
        cpu_pc = cpu_pc + 16'd1;
        return b;
    endfunction

    function automatic logic [7:0] inc_reg8(logic [7:0] v);
        logic [7:0] r;
        r = v + 8'd1;
        cpu_f = (cpu_f & FLG_C) | (r & z80s_pkg::F_SYX) | ((r == 8'd0) ? FLG_Z : 8'd0)
              | ((v[3:0] == 4'hF) ? FLG_H : 8'd0) | ((v == 8'h7F) ? FLG_PV : 8'd0);
        return r;
    endfunction

    function automatic logic [7:0] dec_reg8(logic [7:0] v);
        logic [7:0] r;
        r = v - 8'd1;
        cpu_f = (cpu_f & FLG_C) | (r & z80s_pkg::F_SYX) | ((r == 8'd0) ? FLG_Z : 8'd0)
              | ((v[3:0] == 4'h0) ? FLG_H : 8'd0) | ((v == 8'h80) ? FLG_PV : 8'd0)
              | FLG_N;
        return r;
    endfunction

    function automatic void add_to_hl(logic [15:0] v);
        logic [16:0] sum;
        sum = {1'b0, cpu_hl} + {1'b0, v};
        cpu_f = (cpu_f & z80s_pkg::F_SZPV) | (sum[15:8] & z80s_pkg::F_YX)
              | (({1'b0, cpu_hl[11:0]} + {1'b0, v[11:0]}) > 13'hFFF ? FLG_H : 8'd0)
              | {7'd0, sum[16]};
        cpu_hl = sum[15:0];
    endfunction

    function automatic void rel_jump(logic [7:0] d);
        cpu_pc = cpu_pc + {{8{d[7]}}, d};
    endfunction

    // runs one instruction, returns 1 for an opcode outside the subset
    function automatic logic run_instruction();
        logic [7:0] op, lo, hi, t;
        logic [15:0] sw;
        op = fetch_byte();
        case (op)
            z80s_pkg::OP_NOP: ;
            z80s_pkg::OP_LD_BC: begin
                lo = fetch_byte(); hi = fetch_byte(); cpu_bc = {hi, lo};
            end
            z80s_pkg::OP_ST_BC: begin
                cpu_mem[cpu_bc] = cpu_a; mem_valid[cpu_bc] = 1;
            end
            z80s_pkg::OP_INC_BC: cpu_bc = cpu_bc + 16'd1;
            z80s_pkg::OP_INC_B:  cpu_bc[15:8] = inc_reg8(cpu_bc[15:8]);
            z80s_pkg::OP_DEC_B:  cpu_bc[15:8] = dec_reg8(cpu_bc[15:8]);
            z80s_pkg::OP_LD_B:   cpu_bc[15:8] = fetch_byte();
            z80s_pkg::OP_RLCA: begin
                cpu_a = {cpu_a[6:0], cpu_a[7]};
                cpu_f = (cpu_f & z80s_pkg::F_SZPV) | (cpu_a & z80s_pkg::F_YX)
                      | {7'd0, cpu_a[0]};
            end
            z80s_pkg::OP_EX_AF: begin
                sw = cpu_af_alt; cpu_af_alt = {cpu_a, cpu_f};
                cpu_a = sw[15:8]; cpu_f = sw[7:0];
            end
            z80s_pkg::OP_ADD_BC: add_to_hl(cpu_bc);
            z80s_pkg::OP_LDA_BC: cpu_a = cpu_mem[cpu_bc];
            z80s_pkg::OP_DEC_BC: cpu_bc = cpu_bc - 16'd1;
            z80s_pkg::OP_INC_C:  cpu_bc[7:0] = inc_reg8(cpu_bc[7:0]);
            z80s_pkg::OP_DEC_C:  cpu_bc[7:0] = dec_reg8(cpu_bc[7:0]);
            z80s_pkg::OP_LD_C:   cpu_bc[7:0] = fetch_byte();
            z80s_pkg::OP_RRCA: begin
                cpu_a = {cpu_a[0], cpu_a[7:1]};
                cpu_f = (cpu_f & z80s_pkg::F_SZPV) | (cpu_a & z80s_pkg::F_YX)
                      | {7'd0, cpu_a[7]};
            end
            z80s_pkg::OP_DJNZ: begin
                lo = fetch_byte();
                t = cpu_bc[15:8] - 8'd1;
                cpu_bc[15:8] = t;
                if (t != 8'd0) rel_jump(lo);
            end
            z80s_pkg::OP_LD_DE: begin
                lo = fetch_byte(); hi = fetch_byte(); cpu_de = {hi, lo};
            end
            z80s_pkg::OP_ST_DE: begin
                cpu_mem[cpu_de] = cpu_a; mem_valid[cpu_de] = 1;
            end
            z80s_pkg::OP_INC_DE: cpu_de = cpu_de + 16'd1;
            z80s_pkg::OP_INC_D:  cpu_de[15:8] = inc_reg8(cpu_de[15:8]);
            z80s_pkg::OP_DEC_D:  cpu_de[15:8] = dec_reg8(cpu_de[15:8]);
            z80s_pkg::OP_LD_D:   cpu_de[15:8] = fetch_byte();
            z80s_pkg::OP_RLA: begin
                t = cpu_a;
                cpu_a = {cpu_a[6:0], cpu_f[0]};
                cpu_f = (cpu_f & z80s_pkg::F_SZPV) | (cpu_a & z80s_pkg::F_YX)
                      | {7'd0, t[7]};
            end
            z80s_pkg::OP_JR: begin
                lo = fetch_byte(); rel_jump(lo);
            end
            z80s_pkg::OP_ADD_DE: add_to_hl(cpu_de);
            z80s_pkg::OP_HALT:   cpu_halt = 1'b1;
            default:   return 1'b1;
        endcase
        return 1'b0;
    endfunction

    // applies one accepted command and queues the register view it yields
    function automatic void apply_command(logic [1:0] cmd, logic [15:0] addr, logic [7:0] wd);
        t_cpu_view v;
        v = '0;
        if (cmd == z80s_pkg::CMD_WRITE) begin
            cpu_mem[addr] = wd; mem_valid[addr] = 1;
        end else if (cmd == z80s_pkg::CMD_READ) begin
            v.rdata = cpu_mem[addr];
        end else if (cmd == z80s_pkg::CMD_STEP && !cpu_halt) begin
            v.unsup = run_instruction();
        end
        v.pc = cpu_pc; v.acc = cpu_a; v.flags = cpu_f;
        v.bc = cpu_bc; v.de = cpu_de; v.hl = cpu_hl; v.halted = cpu_halt;
        expected_q.push_back(v);
    endfunction

    // called and returning at a falling edge; valid stays high between back-to-back words
    task automatic send_word(logic [1:0] cmd, logic [15:0] addr, logic [7:0] wd);
        while ($urandom_range(99) < idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {6'd0, wd, addr, cmd};
        do @(posedge i_clk); while (!s_axis_tready);
        apply_command(cmd, addr, wd);
        @(negedge i_clk);
    endtask

    // places an instruction at pc and executes it; keeps every fetched byte written
    task automatic step_op(logic [7:0] op, logic [7:0] b1, logic [7:0] b2);
        if (op == z80s_pkg::OP_LDA_BC && !mem_valid[cpu_bc])
            send_word(z80s_pkg::CMD_WRITE, cpu_bc, 8'($urandom));
        send_word(z80s_pkg::CMD_WRITE, cpu_pc, op);
        send_word(z80s_pkg::CMD_WRITE, cpu_pc + 16'd1, b1);
        send_word(z80s_pkg::CMD_WRITE, cpu_pc + 16'd2, b2);
        send_word(z80s_pkg::CMD_STEP, 16'($urandom), 8'($urandom));
    endtask

    task automatic random_op();
        logic [7:0] op;
        int         pick;
        logic [15:0] a;
        pick = $urandom_range(99);
        if (pick < 65) begin
            step_op(8'($urandom_range(0, 8'h19)), 8'($urandom), 8'($urandom));
        end else if (pick < 72) begin
            op = 8'($urandom_range(8'h1A, 8'hFF));
            if (op == z80s_pkg::OP_HALT) op = 8'h77;
            step_op(op, 8'($urandom), 8'($urandom));
        end else if (pick < 82) begin
            send_word(z80s_pkg::CMD_WRITE, 16'($urandom), 8'($urandom));
        end else if (pick < 95) begin
            a = 16'($urandom);
            if (!mem_valid[a]) a = cpu_pc - 16'd1;
            if (!mem_valid[a]) send_word(z80s_pkg::CMD_WRITE, a, 8'($urandom));
            send_word(z80s_pkg::CMD_READ, a, 8'($urandom));
        end else begin
            send_word(CMD_NONE, 16'($urandom), 8'($urandom));
        end
    endtask

    task automatic test_memory_edges();
        send_word(z80s_pkg::CMD_WRITE, 16'h0000, 8'hFF);
        send_word(z80s_pkg::CMD_WRITE, 16'hFFFF, 8'h00);
        send_word(z80s_pkg::CMD_READ, 16'h0000, 8'h00);
        send_word(z80s_pkg::CMD_READ, 16'hFFFF, 8'hFF);
        send_word(CMD_NONE, 16'hFFFF, 8'hFF);
    endtask

    task automatic test_each_opcode();
        step_op(z80s_pkg::OP_LD_BC, 8'h0F, 8'h7F);
        step_op(z80s_pkg::OP_INC_B, 8'h00, 8'h00);     // 0x7f overflows
        step_op(z80s_pkg::OP_DEC_B, 8'h00, 8'h00);     // 0x80 overflows back
        step_op(z80s_pkg::OP_INC_C, 8'h00, 8'h00);     // half carry out of 0x0f
        step_op(z80s_pkg::OP_LD_DE, 8'hFF, 8'hFF);
        step_op(z80s_pkg::OP_ADD_DE, 8'h00, 8'h00);
        step_op(z80s_pkg::OP_INC_DE, 8'h00, 8'h00);
        step_op(z80s_pkg::OP_ST_BC, 8'h00, 8'h00);
        step_op(z80s_pkg::OP_LDA_BC, 8'h00, 8'h00);
        step_op(z80s_pkg::OP_ST_DE, 8'h00, 8'h00);
        for (int op = 0; op <= 8'h19; op++)
            step_op(8'(op), 8'($urandom), 8'($urandom));
        step_op(z80s_pkg::OP_LD_B, 8'h01, 8'h00);
        step_op(z80s_pkg::OP_DJNZ, 8'h80, 8'h00);      // b reaches zero, no jump
        step_op(z80s_pkg::OP_DJNZ, 8'hFE, 8'h00);      // b wraps to 0xff, backward jump
        step_op(z80s_pkg::OP_JR, 8'h7F, 8'h00);
        step_op(8'hFF, 8'h00, 8'h00);
    endtask

    task automatic test_random_phase(int n, int idle, int stall);
        idle_pct  = idle;
        stall_pct = stall;
        for (int k = 0; k < n; k++) random_op();
    endtask

    task automatic test_halt();
        step_op(z80s_pkg::OP_HALT, 8'h00, 8'h00);
        send_word(z80s_pkg::CMD_STEP, 16'h0000, 8'h00);
        send_word(z80s_pkg::CMD_WRITE, 16'h1234, 8'h5A);
        send_word(z80s_pkg::CMD_READ, 16'h1234, 8'h00);
        send_word(CMD_NONE, 16'h0000, 8'h00);
    endtask

    // receiver and result checks
    always @(negedge i_clk) begin
        if (i_rst_n) m_axis_tready <= ($urandom_range(99) >= stall_pct);
    end

    always @(posedge i_clk) begin
        t_cpu_view exp_v, got;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = {m_axis_tdata[7:0], m_axis_tdata[23:8], m_axis_tdata[31:24],
                   m_axis_tdata[39:32], m_axis_tdata[55:40], m_axis_tdata[71:56],
                   m_axis_tdata[87:72], m_axis_tdata[88], m_axis_tdata[89]};
            if (expected_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected word %h", got);
            end else begin
                exp_v = expected_q.pop_front();
                if (got !== exp_v) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: rd %h/%h pc %h/%h a %h/%h f %h/%h bc %h/%h de %h/%h hl %h/%h h %b/%b u %b/%b (exp/got)",
                                 exp_v.rdata, got.rdata, exp_v.pc, got.pc, exp_v.acc, got.acc,
                                 exp_v.flags, got.flags, exp_v.bc, got.bc, exp_v.de, got.de,
                                 exp_v.hl, got.hl, exp_v.halted, got.halted,
                                 exp_v.unsup, got.unsup);
                end
            end
        end
    end

    // watchdog on cycles with no accepted word on either side
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    initial begin
        int drain;
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        m_axis_tready = 1'b0;
        idle_pct      = 0;
        stall_pct     = 0;
        cpu_pc = '0; cpu_a = '0; cpu_f = '0; cpu_bc = '0;
        cpu_de = '0; cpu_hl = '0; cpu_af_alt = '0; cpu_halt = 1'b0;
        for (int k = 0; k < 65536; k++) begin
            cpu_mem[k] = 8'h00; mem_valid[k] = 0;
        end
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_memory_edges();
        test_each_opcode();
        test_random_phase(40, 0, 0);
        test_random_phase(40, 80, 0);
        test_random_phase(40, 0, 80);
        test_random_phase(40, 24, 24);
        test_halt();
        s_axis_tvalid <= 1'b0;

        while (expected_q.size() != 0) @(posedge i_clk);
        drain = 0;
        while (drain < 20) begin
            @(posedge i_clk);
            drain++;
        end
        if (mismatches == 0 && expected_q.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
